FILE: rtl/core/mlfd_pkg.sv
// Shared types and constants of the meter link frame deframer.
package mlfd_pkg;

   localparam int unsigned ADDRESS_BYTES = 6;
   localparam int unsigned ADDR_W        = 8 * ADDRESS_BYTES;
   localparam int unsigned INFO_BYTES    = 5;
   localparam int unsigned INFO_W        = 8 * INFO_BYTES;

   localparam logic [7:0]  START_BYTE     = 8'h68;
   localparam logic [7:0]  END_BYTE       = 8'h16;
   localparam logic [15:0] BASE_FRAME_LEN = 16'd15;
   localparam logic [15:0] ADDR_FRAME_LEN = BASE_FRAME_LEN + 16'(2 * ADDRESS_BYTES);

   localparam logic [15:0] MAX_LEN_RESET   = 16'd2048;
   localparam logic [2:0]  ADDR_FLAG_RESET = 3'd2;

   localparam int unsigned CSR_IDX_W     = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LEN   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ADDR_FLAG = 2'd1;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_CHECKSUM = 2'd1;
   localparam logic [1:0] ST_END      = 2'd2;
   localparam logic [1:0] ST_LENGTH   = 2'd3;

   typedef enum logic [3:0] {
      PH_HUNT,
      PH_LEN_LO,
      PH_LEN_HI,
      PH_CONTROL,
      PH_INFO,
      PH_SEQ,
      PH_SRC,
      PH_DST,
      PH_FUNC,
      PH_DID_LO,
      PH_DID_HI,
      PH_PAYLOAD,
      PH_CS,
      PH_END
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       restart;
   } req_type;

   typedef struct packed {
      logic              is_payload;
      logic [7:0]        payload_byte;
      logic              frame_done;
      logic [1:0]        status;
      logic [7:0]        control;
      logic [INFO_W-1:0] info;
      logic [7:0]        sequence_res;
      logic [ADDR_W-1:0] source_address;
      logic [ADDR_W-1:0] dest_address;
      logic [7:0]        function_code;
      logic [15:0]       data_id;
      logic [15:0]       payload_length;
   } rsp_type;

   typedef struct packed {
      logic [15:0] max_frame_length;
      logic [2:0]  address_flag_bit;
   } cfg_type;

endpackage

FILE: rtl/core/mlfd_if.sv
// Channel interfaces: byte input, result output and register write port.
interface mlfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       restart;

   modport source (output valid, output data_byte, output restart, input ready);
   modport sink (input valid, input data_byte, input restart, output ready);
endinterface

interface mlfd_rsp_if import mlfd_pkg::*; ;
   logic              valid;
   logic              ready;
   logic              is_payload;
   logic [7:0]        payload_byte;
   logic              frame_done;
   logic [1:0]        status;
   logic [7:0]        control;
   logic [INFO_W-1:0] info;
   logic [7:0]        sequence_res;
   logic [ADDR_W-1:0] source_address;
   logic [ADDR_W-1:0] dest_address;
   logic [7:0]        function_code;
   logic [15:0]       data_id;
   logic [15:0]       payload_length;

   modport source (output valid, output is_payload, output payload_byte, output frame_done,
                   output status, output control, output info, output sequence_res,
                   output source_address, output dest_address, output function_code,
                   output data_id, output payload_length, input ready);
   modport sink (input valid, input is_payload, input payload_byte, input frame_done,
                 input status, input control, input info, input sequence_res,
                 input source_address, input dest_address, input function_code,
                 input data_id, input payload_length, output ready);
endinterface

interface mlfd_csr_if import mlfd_pkg::*; ;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [15:0]          wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink (input valid, input index, input wdata, output ready);
endinterface

FILE: rtl/core/mlfd_cfg_regs.sv
// Configuration registers: maximum frame length and address flag bit select.
module mlfd_cfg_regs import mlfd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_wdata,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MAX_LEN:   cfg_in.max_frame_length = csr_wdata;
            CSR_ADDR_FLAG: cfg_in.address_flag_bit = csr_wdata[2:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_frame_length <= MAX_LEN_RESET;
         cfg_ff.address_flag_bit <= ADDR_FLAG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: rtl/core/mlfd_in_stage.sv
// Input register: holds one accepted byte until the parser takes it.
module mlfd_in_stage import mlfd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_item,
   output logic    item_valid,
   output req_type item,
   input  logic    item_take
);

   logic    valid_ff;
   logic    valid_in;
   req_type item_ff;

   assign in_ready   = !valid_ff || item_take;
   assign valid_in   = in_ready ? in_valid : valid_ff;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= in_item;
      end
   end

endmodule

FILE: rtl/core/mlfd_parser.sv
// Frame parser: phase sequencer, held header fields and running checksum.
module mlfd_parser import mlfd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  req_type item,
   input  logic    step,
   output logic    emit,
   output rsp_type result
);

   phase_type         phase_ff, phase_in;
   logic [15:0]       pos_ff, pos_in;
   logic [15:0]       len_ff, len_in;
   logic [7:0]        sum_ff, sum_in;
   logic [7:0]        control_ff, control_in;
   logic [INFO_W-1:0] info_ff, info_in;
   logic [7:0]        seq_ff, seq_in;
   logic [ADDR_W-1:0] src_ff, src_in;
   logic [ADDR_W-1:0] dst_ff, dst_in;
   logic [7:0]        func_ff, func_in;
   logic [15:0]       did_ff, did_in;
   logic              addr_ff, addr_in;

   logic [7:0]  b;
   logic        is_start;
   logic        addr_new;
   logic [15:0] hdr_len;
   logic [15:0] hdr_new;
   logic [15:0] len_full;
   logic        len_bad;
   logic        no_room;
   logic [15:0] pay_len;
   logic [15:0] pos_inc;
   logic [7:0]  sum_add;
   logic        summ;
   logic [1:0]  summ_status;
   logic [15:0] summ_plen;

   assign b        = item.data_byte;
   assign is_start = (b == START_BYTE);
   assign addr_new = b[cfg.address_flag_bit];
   assign hdr_len  = addr_ff ? ADDR_FRAME_LEN : BASE_FRAME_LEN;
   assign hdr_new  = addr_new ? ADDR_FRAME_LEN : BASE_FRAME_LEN;
   assign len_full = {b, len_ff[7:0]};
   assign len_bad  = (len_full < BASE_FRAME_LEN) || (len_full > cfg.max_frame_length);
   assign no_room  = (len_ff < hdr_new);
   assign pay_len  = len_ff - hdr_len;
   assign pos_inc  = pos_ff + 16'd1;
   assign sum_add  = sum_ff + b;

   // next phase and byte counter
   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      if (item.restart) begin
         phase_in = PH_HUNT;
         pos_in   = '0;
      end else begin
         case (phase_ff)
            PH_HUNT: begin
               if (is_start) begin
                  phase_in = PH_LEN_LO;
                  pos_in   = '0;
               end
            end
            PH_LEN_LO: phase_in = PH_LEN_HI;
            PH_LEN_HI: begin
               if (len_bad) begin
                  phase_in = PH_HUNT;
                  pos_in   = '0;
               end else begin
                  phase_in = PH_CONTROL;
               end
            end
            PH_CONTROL: begin
               phase_in = PH_INFO;
               pos_in   = '0;
            end
            PH_INFO: begin
               if (pos_ff == '0 && no_room) begin
                  phase_in = PH_HUNT;
                  pos_in   = '0;
               end else if (pos_inc >= 16'(INFO_BYTES)) begin
                  phase_in = PH_SEQ;
                  pos_in   = '0;
               end else begin
                  pos_in = pos_inc;
               end
            end
            PH_SEQ: begin
               phase_in = addr_ff ? PH_SRC : PH_FUNC;
               pos_in   = '0;
            end
            PH_SRC: begin
               if (pos_inc >= 16'(ADDRESS_BYTES)) begin
                  phase_in = PH_DST;
                  pos_in   = '0;
               end else begin
                  pos_in = pos_inc;
               end
            end
            PH_DST: begin
               if (pos_inc >= 16'(ADDRESS_BYTES)) begin
                  phase_in = PH_FUNC;
                  pos_in   = '0;
               end else begin
                  pos_in = pos_inc;
               end
            end
            PH_FUNC:   phase_in = PH_DID_LO;
            PH_DID_LO: phase_in = PH_DID_HI;
            PH_DID_HI: begin
               phase_in = (len_ff > hdr_len) ? PH_PAYLOAD : PH_CS;
               pos_in   = '0;
            end
            PH_PAYLOAD: begin
               pos_in = pos_inc;
               if (pos_inc >= pay_len) begin
                  phase_in = PH_CS;
               end
            end
            PH_CS: phase_in = PH_END;
            PH_END: begin
               phase_in = PH_HUNT;
               pos_in   = '0;
            end
            default: begin
               phase_in = PH_HUNT;
               pos_in   = '0;
            end
         endcase
      end
   end

   // held fields, checksum and result
   always_comb begin
      len_in      = len_ff;
      sum_in      = sum_ff;
      control_in  = control_ff;
      info_in     = info_ff;
      seq_in      = seq_ff;
      src_in      = src_ff;
      dst_in      = dst_ff;
      func_in     = func_ff;
      did_in      = did_ff;
      addr_in     = addr_ff;
      emit        = 1'b0;
      summ        = 1'b0;
      summ_status = ST_OK;
      summ_plen   = '0;
      result      = '0;
      if (!item.restart) begin
         case (phase_ff)
            PH_HUNT: begin
               if (is_start) begin
                  len_in     = '0;
                  sum_in     = '0;
                  control_in = '0;
                  info_in    = '0;
                  seq_in     = '0;
                  src_in     = '0;
                  dst_in     = '0;
                  func_in    = '0;
                  did_in     = '0;
                  addr_in    = 1'b0;
               end
            end
            PH_LEN_LO: len_in = {8'h00, b};
            PH_LEN_HI: begin
               len_in = len_full;
               if (len_bad) begin
                  summ        = 1'b1;
                  summ_status = ST_LENGTH;
               end
            end
            PH_CONTROL: begin
               sum_in     = sum_add;
               control_in = b;
            end
            PH_INFO: begin
               sum_in = sum_add;
               for (int i = 0; i < INFO_BYTES; i++) begin
                  if (pos_ff[2:0] == 3'(i)) begin
                     info_in[8*i +: 8] = b;
                  end
               end
               if (pos_ff == '0) begin
                  addr_in = addr_new;
                  if (no_room) begin
                     summ        = 1'b1;
                     summ_status = ST_LENGTH;
                  end
               end
            end
            PH_SEQ: begin
               sum_in = sum_add;
               seq_in = b;
            end
            PH_SRC: begin
               sum_in = sum_add;
               for (int i = 0; i < ADDRESS_BYTES; i++) begin
                  if (pos_ff[2:0] == 3'(i)) begin
                     src_in[8*i +: 8] = b;
                  end
               end
            end
            PH_DST: begin
               sum_in = sum_add;
               for (int i = 0; i < ADDRESS_BYTES; i++) begin
                  if (pos_ff[2:0] == 3'(i)) begin
                     dst_in[8*i +: 8] = b;
                  end
               end
            end
            PH_FUNC: begin
               sum_in  = sum_add;
               func_in = b;
            end
            PH_DID_LO: begin
               sum_in = sum_add;
               did_in = {8'h00, b};
            end
            PH_DID_HI: begin
               sum_in = sum_add;
               did_in = {b, did_ff[7:0]};
            end
            PH_PAYLOAD: begin
               sum_in              = sum_add;
               emit                = 1'b1;
               result.is_payload   = 1'b1;
               result.payload_byte = b;
            end
            // zero after the subtract means the checksum matched
            PH_CS: sum_in = sum_ff - b;
            PH_END: begin
               summ      = 1'b1;
               summ_plen = pay_len;
               if (b != END_BYTE) begin
                  summ_status = ST_END;
               end else if (sum_ff != '0) begin
                  summ_status = ST_CHECKSUM;
               end else begin
                  summ_status = ST_OK;
               end
            end
            default: emit = 1'b0;
         endcase
      end
      if (summ) begin
         emit                  = 1'b1;
         result.frame_done     = 1'b1;
         result.status         = summ_status;
         result.control        = control_in;
         result.info           = info_in;
         result.sequence_res   = seq_in;
         result.source_address = src_in;
         result.dest_address   = dst_in;
         result.function_code  = func_in;
         result.data_id        = did_in;
         result.payload_length = summ_plen;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         pos_ff   <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
      end
   end

   // held fields are cleared at every start byte before use
   always_ff @(posedge clock) begin
      if (step) begin
         len_ff     <= len_in;
         sum_ff     <= sum_in;
         control_ff <= control_in;
         info_ff    <= info_in;
         seq_ff     <= seq_in;
         src_ff     <= src_in;
         dst_ff     <= dst_in;
         func_ff    <= func_in;
         did_ff     <= did_in;
         addr_ff    <= addr_in;
      end
   end

endmodule

FILE: rtl/core/mlfd_out_stage.sv
// Result register: holds one result until the downstream side takes it.
module mlfd_out_stage import mlfd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type load_data,
   output logic    free,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   assign free      = !valid_ff || rsp_ready;
   assign valid_in  = load || (valid_ff && !rsp_ready);
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule

FILE: rtl/core/meter_link_frame_deframer.sv
// Top level of the meter link frame deframer.
// Takes one stream byte per cycle and delivers at most one result per byte: a payload
// pass-through item for each data unit byte, and one summary item with header fields and
// a status at the end of each frame attempt (good frame, checksum mismatch, missing end
// byte, or bad length). A byte passes through an input register and the parser's
// step into a result register, and a new byte is taken every cycle as long as the
// result side keeps up; the parser only waits when the result register is still full
// and the byte at hand makes a result. Bytes other than 0x68 while hunting, and any
// byte with restart set, make no result. Register writes are taken in any cycle and
// must be made while no frame is in progress.
module meter_link_frame_deframer import mlfd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   mlfd_req_if.sink    req_if,
   mlfd_rsp_if.source  rsp_if,
   mlfd_csr_if.sink    csr_if
);

   cfg_type cfg;
   req_type in_item;
   req_type item;
   logic    item_valid;
   logic    step;
   logic    emit;
   logic    out_free;
   rsp_type result;
   rsp_type rsp_data;

   assign in_item.data_byte = req_if.data_byte;
   assign in_item.restart   = req_if.restart;

   // advance unless a result is due and the result register is still occupied
   assign step = item_valid && (out_free || !emit);

   mlfd_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_if.valid),
      .csr_ready (csr_if.ready),
      .csr_index (csr_if.index),
      .csr_wdata (csr_if.wdata),
      .cfg       (cfg)
   );

   mlfd_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_if.valid),
      .in_ready   (req_if.ready),
      .in_item    (in_item),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (step)
   );

   mlfd_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .item   (item),
      .step   (step),
      .emit   (emit),
      .result (result)
   );

   mlfd_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (step && emit),
      .load_data (result),
      .free      (out_free),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_if.is_payload     = rsp_data.is_payload;
   assign rsp_if.payload_byte   = rsp_data.payload_byte;
   assign rsp_if.frame_done     = rsp_data.frame_done;
   assign rsp_if.status         = rsp_data.status;
   assign rsp_if.control        = rsp_data.control;
   assign rsp_if.info           = rsp_data.info;
   assign rsp_if.sequence_res   = rsp_data.sequence_res;
   assign rsp_if.source_address = rsp_data.source_address;
   assign rsp_if.dest_address   = rsp_data.dest_address;
   assign rsp_if.function_code  = rsp_data.function_code;
   assign rsp_if.data_id        = rsp_data.data_id;
   assign rsp_if.payload_length = rsp_data.payload_length;

endmodule

FILE: rtl/core/mlfd_checker.sv
// Port-level checks of the deframer, bound to the top level.
module mlfd_checker import mlfd_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_is_payload,
   input logic [7:0]  rsp_payload_byte,
   input logic        rsp_frame_done,
   input logic [1:0]  rsp_status,
   input logic [15:0] rsp_payload_length
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_payload_byte) && $stable(rsp_status)
                                  && $stable(rsp_payload_length))
      else $error("stalled result changed");

   // every result is either a payload byte or a summary
   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_payload ^ rsp_frame_done))
      else $error("result is neither or both kinds");

   // a length error never reports a payload
   a_len_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done && rsp_status == ST_LENGTH |-> rsp_payload_length == '0)
      else $error("length error with payload length");

   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_payload |-> rsp_status == ST_OK && rsp_payload_length == '0)
      else $error("payload item carries summary fields");

endmodule

bind meter_link_frame_deframer mlfd_checker u_mlfd_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_if.valid),
   .rsp_ready          (rsp_if.ready),
   .rsp_is_payload     (rsp_if.is_payload),
   .rsp_payload_byte   (rsp_if.payload_byte),
   .rsp_frame_done     (rsp_if.frame_done),
   .rsp_status         (rsp_if.status),
   .rsp_payload_length (rsp_if.payload_length)
);
